@@ design/tensor_basis_product_by_index_defines.svh @@
// Assertion macros shared by the checker of the basis product block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TENSOR_BASIS_PRODUCT_BY_INDEX_DEFINES_SVH
`define TENSOR_BASIS_PRODUCT_BY_INDEX_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TBP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles
`define TBP_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

@@ design/tbp_pkg.sv @@
// Package for the tensor basis product block: field widths, codes and
// the small constant-divisor helper. No dependencies.
`default_nettype none

package tbp_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 12;
    localparam int ROW_IN_W = 8;
    localparam int CFG_W    = 3;
    localparam int BASE_W   = 5;   // holds a digit base up to 16
    localparam int RECIP_S  = 13;  // reciprocal scale, 2^13 > 2 * max position
    localparam int RECIP_W  = 14;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int DEF_ROWS      = 256;
    localparam int DEF_MAX_BASIS = 4;
    localparam int DEF_MAX_DIMS  = 6;

    localparam logic [CFG_W-1:0] BASIS_SIZE_RST = 3'd4;
    localparam logic [CFG_W-1:0] DIM_COUNT_RST  = 3'd6;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_COMPUTE = 1'b1
    } op_t;

    typedef enum logic {
        REG_BASIS_SIZE = 1'b0,
        REG_DIM_COUNT  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0] quo;
        logic [POS_W-1:0] rem;
    } divmod_t;

    // floor(2^RECIP_S / den) for den in 1..16
    function automatic logic [RECIP_W-1:0] recip_lut(input logic [BASE_W-1:0] den);
        logic [RECIP_W-1:0] r;
        case (den)
            5'd1:    r = 14'd8192;
            5'd2:    r = 14'd4096;
            5'd3:    r = 14'd2730;
            5'd4:    r = 14'd2048;
            5'd5:    r = 14'd1638;
            5'd6:    r = 14'd1365;
            5'd7:    r = 14'd1170;
            5'd8:    r = 14'd1024;
            5'd9:    r = 14'd910;
            5'd10:   r = 14'd819;
            5'd11:   r = 14'd744;
            5'd12:   r = 14'd682;
            5'd13:   r = 14'd630;
            5'd14:   r = 14'd585;
            5'd15:   r = 14'd546;
            5'd16:   r = 14'd512;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Quotient and remainder of a position by a small base: reciprocal
    // multiply gives the quotient or one less, one correction step fixes it
    function automatic divmod_t divmod_small(input logic [POS_W-1:0] num,
                                             input logic [BASE_W-1:0] den);
        logic [POS_W+RECIP_W-1:0] prod;
        logic [POS_W-1:0]         q;
        logic [POS_W+BASE_W-1:0]  back;
        logic [POS_W:0]           r;
        divmod_t                  res;
        prod = (POS_W+RECIP_W)'(num) * (POS_W+RECIP_W)'(recip_lut(den));
        q    = prod[RECIP_S +: POS_W];
        back = (POS_W+BASE_W)'(q) * (POS_W+BASE_W)'(den);
        r    = {1'b0, num} - (POS_W+1)'(back);
        if (r >= (POS_W+1)'(den)) begin
            q = q + 1'b1;
            r = r - (POS_W+1)'(den);
        end
        res.quo = q;
        res.rem = r[POS_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/tensor_basis_product_by_index.sv @@
// Top level of the tensor basis product block: coefficient tables, digit
// split pipeline, table reads and the fixed-point product chain. Uses tbp_pkg.
`default_nettype none

// One item is taken every clock cycle; busy never rises. A compute item passes
// through one input stage, one stage per position digit, one table read, two
// stages (multiply, then round and saturate) per dimension of the product
// chain and the output register. Write items give no result and reach the
// table memory at the same point of the pipeline where compute items read
// it, so items always see the tables in order. Each table has a single port,
// one access a cycle, which sets the rate of one item per cycle. The tables
// are not cleared after reset; an entry must be written before any compute
// item reads it. The receiver cannot stall: done marks each result for
// exactly one cycle. Configuration registers may only change while no item
// is in flight.
module tensor_basis_product_by_index
    import tbp_pkg::*;
#(
    parameter int ROWS      = DEF_ROWS,
    parameter int MAX_BASIS = DEF_MAX_BASIS,
    parameter int MAX_DIMS  = DEF_MAX_DIMS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // command side
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       operation,
    input  wire logic [2:0]                 table_sel,
    input  wire logic [ROW_IN_W-1:0]        row_dim0,
    input  wire logic [ROW_IN_W-1:0]        row_dim1,
    input  wire logic [ROW_IN_W-1:0]        row_dim2,
    input  wire logic [ROW_IN_W-1:0]        row_dim3,
    input  wire logic [ROW_IN_W-1:0]        row_dim4,
    input  wire logic [ROW_IN_W-1:0]        row_dim5,
    input  wire logic [POS_W-1:0]           position,
    input  wire logic signed [DATA_W-1:0]   coeff_value,
    input  wire logic                       last_item,
    // result side
    output logic                            done,
    output logic signed [DATA_W-1:0]        product,
    output logic [POS_W-1:0]                out_position,
    output logic                            bad_position,
    output logic                            last_result,
    // register port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [PADDR_W-1:0]         paddr,
    input  wire logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]              prdata,
    output logic                            pready
);

    localparam int M         = MAX_DIMS;
    localparam int COL_W     = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH     = ROWS * MAX_BASIS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_RECIP = (ROWS >= 256) ? 1 : 65536 / ROWS;

    typedef struct packed {
        op_t                        op;
        logic [2:0]                 table_sel;
        logic [M-1:0][ROW_W-1:0]    rows;
        logic [COL_W-1:0]           wr_col;
        logic [DATA_W-1:0]          wr_data;
        logic [POS_W-1:0]           pos;
        logic [POS_W-1:0]           rem;
        logic [M-1:0][COL_W-1:0]    digits;
        logic                       last;
    } front_t;

    typedef struct packed {
        logic                       bad;
        logic [POS_W-1:0]           pos;
        logic                       last;
    } tag_t;

    typedef struct packed {
        tag_t                       tag;
        logic                       raw;
        logic signed [DATA_W-1:0]   v;
        logic signed [2*DATA_W-1:0] prod;
        logic [M-1:0][DATA_W-1:0]   coef;
    } mul_t;

    typedef struct packed {
        tag_t                       tag;
        logic signed [DATA_W-1:0]   v;
        logic [M-1:0][DATA_W-1:0]   coef;
    } acc_t;

    // Row index modulo ROWS; row < 256 so reciprocal plus one correction
    function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_IN_W-1:0] r);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [15:0] back;
        logic [8:0]  rem;
        prod = 25'(r) * 25'(ROW_RECIP);
        q    = prod[23:16];
        back = 16'(q) * 16'(ROWS);
        rem  = {1'b0, r} - 9'(back);
        if (rem >= 9'(ROWS)) begin
            rem = rem - 9'(ROWS);
        end
        if (ROWS >= 256) begin
            return ROW_W'(r);
        end
        return ROW_W'(rem);
    endfunction

    function automatic logic [ADDR_W-1:0] row_col_addr(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_BASIS) + ADDR_W'(col));
    endfunction

    // Q8.24 product rounding: add half an LSB, floor, saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [2*DATA_W-1:0] p);
        logic signed [2*DATA_W-1:0] s;
        logic [39:0]                q;
        s = p + 64'sd8388608;
        q = s[63:24];
        if ((&q[39:31]) || !(|q[39:31])) begin
            return $signed(q[31:0]);
        end
        if (q[39]) begin
            return 32'sh8000_0000;
        end
        return 32'sh7fff_ffff;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    logic [CFG_W-1:0]  basis_size_reg;
    logic [CFG_W-1:0]  dim_count_reg;
    logic [BASE_W-1:0] n_sat;
    logic [CFG_W-1:0]  d_sat;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            basis_size_reg <= BASIS_SIZE_RST;
            dim_count_reg  <= DIM_COUNT_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_BASIS_SIZE: basis_size_reg <= pwdata[CFG_W-1:0];
                REG_DIM_COUNT:  dim_count_reg  <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_BASIS_SIZE: prdata = PDATA_W'(basis_size_reg);
            REG_DIM_COUNT:  prdata = PDATA_W'(dim_count_reg);
        endcase
    end

    assign pready = 1'b1;

    // Clamp base and dimension count into their supported ranges
    always_comb begin
        if (basis_size_reg == '0) begin
            n_sat = BASE_W'(1);
        end else if (int'(basis_size_reg) > MAX_BASIS) begin
            n_sat = BASE_W'(MAX_BASIS);
        end else begin
            n_sat = BASE_W'(basis_size_reg);
        end
        if (dim_count_reg == '0) begin
            d_sat = CFG_W'(1);
        end else if (int'(dim_count_reg) > MAX_DIMS) begin
            d_sat = CFG_W'(MAX_DIMS);
        end else begin
            d_sat = dim_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Front pipeline: input stage then one digit per stage
    logic [5:0][ROW_IN_W-1:0] row_in;
    logic [M:0]               front_vld_reg;
    front_t                   front_reg  [M+1];
    front_t                   front_next [M+1];

    assign busy   = 1'b0;
    assign row_in = {row_dim5, row_dim4, row_dim3, row_dim2, row_dim1, row_dim0};

    always_comb begin
        divmod_t dm_col;
        divmod_t dm;
        dm     = '0;
        dm_col = divmod_small(position, BASE_W'(MAX_BASIS));
        front_next[0].op        = op_t'(operation);
        front_next[0].table_sel = table_sel;
        for (int k = 0; k < M; k++) begin
            front_next[0].rows[k] = wrap_row(row_in[k]);
        end
        front_next[0].wr_col  = COL_W'(dm_col.rem);
        front_next[0].wr_data = coeff_value;
        front_next[0].pos     = position;
        front_next[0].rem     = position;
        front_next[0].digits  = '0;
        front_next[0].last    = last_item;

        // stage j peels the digit of dimension d-1-j
        for (int j = 0; j < M; j++) begin
            front_next[j+1] = front_reg[j];
            if (j < int'(d_sat)) begin
                dm = divmod_small(front_reg[j].rem, n_sat);
                front_next[j+1].rem = dm.quo;
                for (int k = 0; k < M; k++) begin
                    if (k == int'(d_sat) - 1 - j) begin
                        front_next[j+1].digits[k] = COL_W'(dm.rem);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            front_vld_reg <= '0;
        end else begin
            front_vld_reg <= {front_vld_reg[M-1:0], start && !busy};
        end
    end

    always_ff @(posedge clk) begin
        for (int j = 0; j <= M; j++) begin
            front_reg[j] <= front_next[j];
        end
    end

    // ------------------------------------------------------------------
    // Table memories: writes and reads meet here in item order
    logic [M-1:0][DATA_W-1:0] rd_data;
    logic                     mem_vld_reg;
    tag_t                     tag_reg;

    for (genvar t = 0; t < M; t++) begin : g_table
        logic [DATA_W-1:0] mem [DEPTH];
        logic [DATA_W-1:0] rd_q_reg;
        logic [ADDR_W-1:0] addr;
        logic              we;
        logic              re;

        assign we = front_vld_reg[M] && (front_reg[M].op == OP_WRITE)
                    && (front_reg[M].table_sel == 3'(t));
        assign re = front_vld_reg[M] && (front_reg[M].op == OP_COMPUTE);
        assign addr = (front_reg[M].op == OP_WRITE)
                      ? row_col_addr(front_reg[M].rows[0], front_reg[M].wr_col)
                      : row_col_addr(front_reg[M].rows[t], front_reg[M].digits[t]);

        always_ff @(posedge clk) begin
            if (we) begin
                mem[addr] <= front_reg[M].wr_data;
            end
            if (re) begin
                rd_q_reg <= mem[addr];
            end
        end

        assign rd_data[t] = rd_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mem_vld_reg <= 1'b0;
        end else begin
            mem_vld_reg <= front_vld_reg[M] && (front_reg[M].op == OP_COMPUTE);
        end
    end

    // leftover quotient means the position was at or past the base to the power of the dim count
    always_ff @(posedge clk) begin
        tag_reg.bad  <= (front_reg[M].rem != '0);
        tag_reg.pos  <= front_reg[M].pos;
        tag_reg.last <= front_reg[M].last;
    end

    // ------------------------------------------------------------------
    // Product chain, last dimension first: multiply stage, round stage
    logic [M-1:0] mul_vld_reg;
    logic [M-1:0] acc_vld_reg;
    acc_t         acc_src  [M];
    mul_t         mul_reg  [M];
    mul_t         mul_next [M];
    acc_t         acc_reg  [M];
    acc_t         acc_next [M];

    always_comb begin
        int k;
        acc_src[0].tag  = tag_reg;
        acc_src[0].v    = '0;
        acc_src[0].coef = rd_data;
        for (int s = 1; s < M; s++) begin
            acc_src[s] = acc_reg[s-1];
        end
        for (int s = 0; s < M; s++) begin
            k = M - 1 - s;
            mul_next[s].tag  = acc_src[s].tag;
            mul_next[s].coef = acc_src[s].coef;
            mul_next[s].raw  = (k >= int'(d_sat)) || (k == int'(d_sat) - 1);
            mul_next[s].v    = (k == int'(d_sat) - 1) ? $signed(acc_src[s].coef[k])
                                                      : acc_src[s].v;
            mul_next[s].prod = $signed(acc_src[s].v) * $signed(acc_src[s].coef[k]);

            acc_next[s].tag  = mul_reg[s].tag;
            acc_next[s].coef = mul_reg[s].coef;
            acc_next[s].v    = mul_reg[s].raw ? mul_reg[s].v : round_sat(mul_reg[s].prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mul_vld_reg <= '0;
            acc_vld_reg <= '0;
        end else begin
            for (int s = 0; s < M; s++) begin
                mul_vld_reg[s] <= (s == 0) ? mem_vld_reg : acc_vld_reg[(s == 0) ? 0 : s-1];
                acc_vld_reg[s] <= mul_vld_reg[s];
            end
        end
    end

    always_ff @(posedge clk) begin
        for (int s = 0; s < M; s++) begin
            mul_reg[s] <= mul_next[s];
            acc_reg[s] <= acc_next[s];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    logic                     done_reg;
    logic signed [DATA_W-1:0] product_reg;
    logic [POS_W-1:0]         out_position_reg;
    logic                     bad_position_reg;
    logic                     last_result_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= acc_vld_reg[M-1];
        end
    end

    always_ff @(posedge clk) begin
        product_reg      <= acc_reg[M-1].tag.bad ? '0 : acc_reg[M-1].v;
        out_position_reg <= acc_reg[M-1].tag.pos;
        bad_position_reg <= acc_reg[M-1].tag.bad;
        last_result_reg  <= acc_reg[M-1].tag.last;
    end

    assign done         = done_reg;
    assign product      = product_reg;
    assign out_position = out_position_reg;
    assign bad_position = bad_position_reg;
    assign last_result  = last_result_reg;

endmodule

`default_nettype wire

@@ design/tbp_checker.sv @@
// Port-level checker for the tensor basis product block, bound to its top.
// Uses tbp_pkg and the assertion macros header.
`default_nettype none
`include "tensor_basis_product_by_index_defines.svh"

module tbp_checker
    import tbp_pkg::*;
#(
    parameter int LATENCY = 3 * DEF_MAX_DIMS + 3
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     operation,
    input wire logic [POS_W-1:0]         position,
    input wire logic                     last_item,
    input wire logic                     done,
    input wire logic signed [DATA_W-1:0] product,
    input wire logic [POS_W-1:0]         out_position,
    input wire logic                     bad_position,
    input wire logic                     last_result
);

    // every compute beat comes out after the fixed latency
    `TBP_ASSERT_DELAY(a_compute_gives_result, start && !busy && (operation == OP_COMPUTE), LATENCY, done, "compute beat without result")

    // every result traces back to a compute beat, with its tags intact
    `TBP_ASSERT_IMPLY(a_result_has_source, done, $past(start && !busy && (operation == OP_COMPUTE), LATENCY) && (out_position == $past(position, LATENCY)) && (last_result == $past(last_item, LATENCY)), "result without matching compute beat")

    // a bad position carries a zero product
    `TBP_ASSERT_IMPLY(a_bad_is_zero, done && bad_position, product == '0, "bad position with non-zero product")

    // position zero is always in range
    `TBP_ASSERT_IMPLY(a_zero_in_range, done && bad_position, out_position != '0, "position zero flagged out of range")

endmodule

bind tensor_basis_product_by_index tbp_checker #(
    .LATENCY(3 * MAX_DIMS + 3)
) u_tbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .position     (position),
    .last_item    (last_item),
    .done         (done),
    .product      (product),
    .out_position (out_position),
    .bad_position (bad_position),
    .last_result  (last_result)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for tensor_basis_product_by_index: directed table, row fills,
// then random command streams over several register settings. Needs tbp_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import tbp_pkg::*;

    localparam logic [DATA_W-1:0] Q_ONE     = 32'h0100_0000;
    localparam logic [DATA_W-1:0] Q_TWO     = 32'h0200_0000;
    localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;
    localparam int                DRAIN_CYC = 32;   // pipeline is 21 deep at six dims
    localparam int                SETTLE    = 2000;
    localparam int                PHASE_LEN = 220;
    localparam int                NUM_PHASE = 8;

    typedef struct packed {
        op_t                          op;
        logic [2:0]                   tsel;
        logic [5:0][ROW_IN_W-1:0]     rows;
        logic [POS_W-1:0]             pos;
        logic [DATA_W-1:0]            coeff;
        logic                         last;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] product;
        logic [POS_W-1:0]  pos;
        logic              bad;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        ROW_CMD,
        ROW_CMD_TYPED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        cmd_t             cmd;
        result_t          typed;
        reg_idx_t         cfg_idx;
        logic [CFG_W-1:0] cfg_val;
    } stim_row_t;

    // DUT signals
    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic [2:0]               table_sel;
    logic [ROW_IN_W-1:0]      row_dim0, row_dim1, row_dim2, row_dim3, row_dim4, row_dim5;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] coeff_value;
    logic                     last_item;
    logic                     done;
    logic signed [DATA_W-1:0] product;
    logic [POS_W-1:0]         out_position;
    logic                     bad_position;
    logic                     last_result;
    logic                     psel, penable, pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    // Predictor state: coefficient tables, fill marks, fully written rows
    logic [DATA_W-1:0]        coeff_mem [DEF_MAX_DIMS][DEF_ROWS][DEF_MAX_BASIS];
    logic [DEF_MAX_BASIS-1:0] filled    [DEF_MAX_DIMS][DEF_ROWS];
    int                       full_rows [DEF_MAX_DIMS][$];
    logic [CFG_W-1:0]         basis_reg;
    logic [CFG_W-1:0]         dims_reg;

    result_t                  pending_products [$];
    stim_row_t                directed_rows [$];
    int                       fail_count = 0;

    tensor_basis_product_by_index uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .table_sel    (table_sel),
        .row_dim0     (row_dim0),
        .row_dim1     (row_dim1),
        .row_dim2     (row_dim2),
        .row_dim3     (row_dim3),
        .row_dim4     (row_dim4),
        .row_dim5     (row_dim5),
        .position     (position),
        .coeff_value  (coeff_value),
        .last_item    (last_item),
        .done         (done),
        .product      (product),
        .out_position (out_position),
        .bad_position (bad_position),
        .last_result  (last_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Register values clamp into their legal range
    function automatic int eff_basis();
        if (basis_reg == 0)
            return 1;
        return (basis_reg > DEF_MAX_BASIS) ? DEF_MAX_BASIS : int'(basis_reg);
    endfunction

    function automatic int eff_dims();
        if (dims_reg == 0)
            return 1;
        return (dims_reg > DEF_MAX_DIMS) ? DEF_MAX_DIMS : int'(dims_reg);
    endfunction

    function automatic int pos_limit(input int n, input int d);
        int lim;
        lim = 1;
        for (int k = 0; k < d; k++)
            lim = lim * n;
        return lim;
    endfunction

    // Q8.24 multiply: round half up at bit 24, then saturate
    function automatic logic [DATA_W-1:0] q824_mul(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b);
        longint wide;
        wide = (longint'(a) * longint'(b) + (longint'(1) << 23)) >>> 24;
        if (wide > longint'(32'sh7FFF_FFFF))
            return Q_MAX;
        if (wide < -longint'(64'sh8000_0000))
            return Q_MIN;
        return wide[DATA_W-1:0];
    endfunction

    // Product of the selected entries, last dimension taking the lowest digit
    function automatic result_t predict_product(input cmd_t c);
        result_t          r;
        int               n, d, rem_i, digit;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] entry;
        n       = eff_basis();
        d       = eff_dims();
        r.pos   = c.pos;
        r.last  = c.last;
        r.bad   = int'(c.pos) >= pos_limit(n, d);
        acc     = '0;
        if (!r.bad)
        begin
            rem_i = c.pos;
            for (int k = d - 1; k >= 0; k--)
            begin
                digit = rem_i % n;
                rem_i = rem_i / n;
                entry = coeff_mem[k][c.rows[k]][digit];
                acc   = (k == d - 1) ? entry : q824_mul(acc, entry);
            end
        end
        r.product = acc;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_coeff();
        case ($urandom_range(7))
            0: return $urandom;
            1: return Q_ONE;
            2: return -Q_ONE;
            3:
            begin
                case ($urandom_range(2))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    default: return '0;
                endcase
            end
            default: return DATA_W'($urandom_range(32'h0400_0000) - 32'h0200_0000);
        endcase
    endfunction

    function automatic int idle_gap(input int pct);
        int g;
        g = 0;
        while ($urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    // Mostly well-formed computes over written rows, some writes, a few ignored writes
    function automatic cmd_t make_random_cmd();
        cmd_t c;
        int   pick, t, n, d, lim, rem_i;
        int   digit [DEF_MAX_DIMS];
        logic bad;
        pick   = $urandom_range(99);
        c.rows = 48'({$urandom, $urandom});
        c.pos  = POS_W'($urandom);
        c.coeff = pick_coeff();
        c.last = ($urandom_range(7) == 0);
        c.tsel = 3'($urandom_range(7));
        if (pick < 5)
        begin
            c.op   = OP_WRITE;
            c.tsel = 3'($urandom_range(7, DEF_MAX_DIMS));
        end
        else if (pick < 30)
        begin
            c.op   = OP_WRITE;
            t      = $urandom_range(DEF_MAX_DIMS - 1);
            c.tsel = 3'(t);
            if ($urandom_range(1))
                c.rows[0] = ROW_IN_W'(full_rows[t][$urandom_range(full_rows[t].size() - 1)]);
        end
        else
        begin
            c.op = OP_COMPUTE;
            n    = eff_basis();
            d    = eff_dims();
            lim  = pos_limit(n, d);
            if (lim < (1 << POS_W) && $urandom_range(9) == 0)
                c.pos = POS_W'($urandom_range((1 << POS_W) - 1, lim));
            else
                c.pos = POS_W'($urandom_range(lim - 1));
            bad   = int'(c.pos) >= lim;
            rem_i = c.pos;
            for (int k = d - 1; k >= 0; k--)
            begin
                digit[k] = rem_i % n;
                rem_i    = rem_i / n;
            end
            // never touch an entry that was not written
            for (int k = 0; k < d; k++)
                if (bad || !filled[k][c.rows[k]][digit[k]])
                    c.rows[k] = ROW_IN_W'(full_rows[k][$urandom_range(full_rows[k].size() - 1)]);
        end
        return c;
    endfunction

    // Update model state on an accepted beat, queue the expected product
    task automatic apply_accepted(input cmd_t c, input logic typed, input result_t typed_res);
        int               col;
        logic [DEF_MAX_BASIS-1:0] was;
        if (c.op == OP_WRITE)
        begin
            if (c.tsel < DEF_MAX_DIMS)
            begin
                col = c.pos % DEF_MAX_BASIS;
                was = filled[c.tsel][c.rows[0]];
                coeff_mem[c.tsel][c.rows[0]][col] = c.coeff;
                filled[c.tsel][c.rows[0]][col]    = 1'b1;
                if (was != '1 && filled[c.tsel][c.rows[0]] == '1)
                    full_rows[c.tsel].push_back(int'(c.rows[0]));
            end
        end
        else
            pending_products.push_back(typed ? typed_res : predict_product(c));
    endtask

    task automatic issue_cmd(input cmd_t c, input int gap, input logic typed,
                             input result_t typed_res);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= c.op;
        table_sel   <= c.tsel;
        row_dim0    <= c.rows[0];
        row_dim1    <= c.rows[1];
        row_dim2    <= c.rows[2];
        row_dim3    <= c.rows[3];
        row_dim4    <= c.rows[4];
        row_dim5    <= c.rows[5];
        position    <= c.pos;
        coeff_value <= c.coeff;
        last_item   <= c.last;
        do
            @(posedge clk);
        while (busy);
        apply_accepted(c, typed, typed_res);
    endtask

    // Register write only once the pipeline has emptied
    task automatic write_cfg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        start <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= (PDATA_W'($urandom) & ~PDATA_W'(7)) | PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BASIS_SIZE)
            basis_reg = val;
        else
            dims_reg = val;
    endtask

    task automatic add_cmd_row(input cmd_t c, input logic typed, input result_t res);
        stim_row_t s;
        s         = '0;
        s.kind    = typed ? ROW_CMD_TYPED : ROW_CMD;
        s.cmd     = c;
        s.typed   = res;
        directed_rows.push_back(s);
    endtask

    task automatic add_cfg_row(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        stim_row_t s;
        s         = '0;
        s.kind    = ROW_CFG;
        s.cfg_idx = idx;
        s.cfg_val = val;
        directed_rows.push_back(s);
    endtask

    // Result checker: done is a one-cycle strobe, no back-pressure
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_products.size() == 0)
            begin
                $display("%0t: unexpected result, product %h position %h", $time,
                         product, out_position);
                fail_count++;
            end
            else
            begin
                want = pending_products.pop_front();
                if (product !== want.product)
                begin
                    $display("%0t: product expected %h actual %h", $time, want.product, product);
                    fail_count++;
                end
                if (out_position !== want.pos)
                begin
                    $display("%0t: out_position expected %h actual %h", $time, want.pos,
                             out_position);
                    fail_count++;
                end
                if (bad_position !== want.bad)
                begin
                    $display("%0t: bad_position expected %b actual %b", $time, want.bad,
                             bad_position);
                    fail_count++;
                end
                if (last_result !== want.last)
                begin
                    $display("%0t: last_result expected %b actual %b", $time, want.last,
                             last_result);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        cmd_t             c;
        result_t          none;
        logic [DATA_W-1:0] far_col [DEF_MAX_DIMS];
        logic [CFG_W-1:0] ph_basis [NUM_PHASE];
        logic [CFG_W-1:0] ph_dims  [NUM_PHASE];
        int               ph_idle  [NUM_PHASE];
        int               seed_row;
        int               w;

        ph_basis = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd3};
        ph_dims  = '{3'd6, 3'd1, 3'd0, 3'd7, 3'd3, 3'd6, 3'd2, 3'd5};
        ph_idle  = '{0, 60, 22, 0, 60, 22, 0, 60};
        far_col  = '{Q_ONE, Q_ONE, Q_TWO, -Q_ONE, Q_MIN, Q_MAX};
        none     = '0;

        start       <= 1'b0;
        operation   <= OP_WRITE;
        table_sel   <= '0;
        row_dim0    <= '0;
        row_dim1    <= '0;
        row_dim2    <= '0;
        row_dim3    <= '0;
        row_dim4    <= '0;
        row_dim5    <= '0;
        position    <= '0;
        coeff_value <= '0;
        last_item   <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        rst_n       <= 1'b0;
        basis_reg    = BASIS_SIZE_RST;
        dims_reg     = DIM_COUNT_RST;
        foreach (filled[t, r])
            filled[t][r] = '0;

        // Directed table: column 0 of row 0 and column 3 of row 255 in every table
        for (int t = 0; t < DEF_MAX_DIMS; t++)
        begin
            c = '{OP_WRITE, 3'(t), '0, '0, Q_ONE, 1'b0};
            add_cmd_row(c, 1'b0, none);
            c = '{OP_WRITE, 3'(t), {6{8'hFF}}, 12'hFFF, far_col[t], 1'b0};
            add_cmd_row(c, 1'b0, none);
        end
        // writes to tables that do not exist must leave the store alone
        c = '{OP_WRITE, 3'd6, '0, '0, '0, 1'b0};
        add_cmd_row(c, 1'b0, none);
        c = '{OP_WRITE, 3'd7, '0, '0, 32'hDEAD_BEEF, 1'b0};
        add_cmd_row(c, 1'b0, none);
        // reset settings: four columns, six dimensions
        c = '{OP_COMPUTE, 3'd0, '0, '0, '0, 1'b0};
        add_cmd_row(c, 1'b1, '{Q_ONE, 12'h000, 1'b0, 1'b0});
        c = '{OP_COMPUTE, 3'd0, {6{8'hFF}}, 12'hFFF, '0, 1'b0};
        add_cmd_row(c, 1'b0, none);
        c = '{OP_COMPUTE, 3'd0, {8'hFF, {5{8'h00}}}, 12'h003, '0, 1'b1};
        add_cmd_row(c, 1'b0, none);
        // basis size zero acts as one, dimension count above six acts as six
        add_cfg_row(REG_BASIS_SIZE, 3'd0);
        add_cfg_row(REG_DIM_COUNT, 3'd7);
        c = '{OP_COMPUTE, 3'd0, '0, 12'h000, '0, 1'b0};
        add_cmd_row(c, 1'b1, '{Q_ONE, 12'h000, 1'b0, 1'b0});
        c = '{OP_COMPUTE, 3'd0, '0, 12'h001, '0, 1'b0};
        add_cmd_row(c, 1'b1, '{32'h0, 12'h001, 1'b1, 1'b0});
        // basis size above four acts as four, zero dimensions act as one
        add_cfg_row(REG_BASIS_SIZE, 3'd7);
        add_cfg_row(REG_DIM_COUNT, 3'd0);
        c = '{OP_COMPUTE, 3'd0, {6{8'hFF}}, 12'h003, '0, 1'b0};
        add_cmd_row(c, 1'b1, '{Q_ONE, 12'h003, 1'b0, 1'b0});
        c = '{OP_COMPUTE, 3'd0, {6{8'hFF}}, 12'h004, '0, 1'b0};
        add_cmd_row(c, 1'b1, '{32'h0, 12'h004, 1'b1, 1'b0});
        c = '{OP_COMPUTE, 3'd0, {6{8'hFF}}, 12'hFFF, '0, 1'b1};
        add_cmd_row(c, 1'b1, '{32'h0, 12'hFFF, 1'b1, 1'b1});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_cfg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            else
                issue_cmd(directed_rows[i].cmd, 0, directed_rows[i].kind == ROW_CMD_TYPED,
                          directed_rows[i].typed);
        end

        // Fill a handful of whole rows per table, both extremes of the index among them
        for (int t = 0; t < DEF_MAX_DIMS; t++)
            for (int s = 0; s < 8; s++)
            begin
                case (s)
                    0:       seed_row = 8'h00;
                    1:       seed_row = 8'hFF;
                    2:       seed_row = 8'h55;
                    3:       seed_row = 8'hAA;
                    default: seed_row = $urandom_range(DEF_ROWS - 1);
                endcase
                for (int col = 0; col < DEF_MAX_BASIS; col++)
                begin
                    c           = '{OP_WRITE, 3'(t), 48'({$urandom, $urandom}), '0,
                                    pick_coeff(), 1'b0};
                    c.rows[0]   = ROW_IN_W'(seed_row);
                    c.pos       = POS_W'({$urandom_range(1023), 2'(col)});
                    issue_cmd(c, idle_gap(22), 1'b0, none);
                end
            end

        // Random streams, one register setting and idle rate per phase
        for (int p = 0; p < NUM_PHASE; p++)
        begin
            write_cfg(REG_BASIS_SIZE, ph_basis[p]);
            write_cfg(REG_DIM_COUNT, ph_dims[p]);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                c = make_random_cmd();
                issue_cmd(c, idle_gap(ph_idle[p]), 1'b0, none);
            end
        end

        start <= 1'b0;
        for (w = 0; w < SETTLE && pending_products.size() != 0; w++)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (pending_products.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_products.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
